// ===== hw/rtl/srrip_pkg.sv =====
// Package for the SHiP/RRIP replacement block: defaults, field widths,
// register map and the controller/datapath command and status types.
// No dependencies.
`default_nettype none
package srrip_pkg;

    localparam int DEF_NUM_SETS          = 2048;
    localparam int DEF_NUM_WAYS          = 16;
    localparam int DEF_SIGNATURE_ENTRIES = 16384;
    localparam int DEF_RRPV_WIDTH        = 2;
    localparam int DEF_COUNTER_WIDTH     = 2;

    localparam int SET_IN_W    = 11;
    localparam int WAY_IN_W    = 4;
    localparam int PC_W        = 64;
    localparam int VICTIM_W    = 4;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int THR_W       = 2;
    localparam int SHIFT_W     = 6;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [THR_W-1:0]   THR_RESET   = 2'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd4;

    // register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_SHIFT     = 1'b1;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_ctr_old;
        logic train;
        logic fin_victim;
        logic fin_hit;
        logic fin_ins;
        logic fin_nop;
    } srrip_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_update;
        logic is_hit;
        logic way_ok;
        logic out_free;
    } srrip_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srrip_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module srrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/srrip_ctrl.sv =====
// Sequencing FSM for the replacement block: clearing pass, row read,
// counter read/train and final write-back. Depends on srrip_pkg.
`default_nettype none
module srrip_ctrl
    import srrip_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire srrip_sts_t sts,
    output srrip_cmd_t      cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_CTR  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                if (!sts.is_update) begin
                    if (sts.out_free) begin
                        cmd.fin_victim = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (!sts.way_ok) begin
                    if (sts.out_free) begin
                        cmd.fin_nop = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.rd_ctr_old = 1'b1;
                    state_next     = ST_CTR;
                end
            end
            ST_CTR: begin
                if (sts.is_hit) begin
                    if (sts.out_free) begin
                        cmd.fin_hit = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.train  = 1'b1;
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                if (sts.out_free) begin
                    cmd.fin_ins = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_victim || cmd.fin_hit || cmd.fin_ins || cmd.fin_nop)
        |=> state_reg == ST_IDLE)
        else $error("finish step not followed by idle");
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !cmd.accept)
        else $error("item accepted during clearing pass");
    a_one_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.fin_victim, cmd.fin_hit, cmd.fin_ins, cmd.fin_nop}))
        else $error("several finish commands");
    a_train_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.train |=> state_reg == ST_INS)
        else $error("training not followed by insertion");

endmodule
`default_nettype wire

// ===== hw/rtl/srrip_dp.sv =====
// Datapath: input capture, per-set line RAM, signature counter RAM,
// victim search/aging, insertion and output register. Depends on srrip_pkg, srrip_ram.
`default_nettype none
module srrip_dp
    import srrip_pkg::*;
#(
    parameter int NUM_SETS          = DEF_NUM_SETS,
    parameter int NUM_WAYS          = DEF_NUM_WAYS,
    parameter int SIGNATURE_ENTRIES = DEF_SIGNATURE_ENTRIES,
    parameter int RRPV_WIDTH        = DEF_RRPV_WIDTH,
    parameter int COUNTER_WIDTH     = DEF_COUNTER_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire srrip_cmd_t           cmd,
    output srrip_sts_t                sts,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic [THR_W-1:0]     thr,
    input  wire logic [SHIFT_W-1:0]   shift,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SIG_W  = $clog2(SIGNATURE_ENTRIES);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int RW     = RRPV_WIDTH;
    localparam int CW     = COUNTER_WIDTH;
    localparam int ROW_W  = NUM_WAYS * (RW + SIG_W + 1);
    localparam int SIG_LO = NUM_WAYS * RW;
    localparam int RU_LO  = NUM_WAYS * (RW + SIG_W);
    localparam int CLR_N  = (NUM_SETS > SIGNATURE_ENTRIES) ? NUM_SETS : SIGNATURE_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int CMP_W  = (CW > THR_W) ? CW : THR_W;
    localparam logic [RW-1:0] RRPV_TOP = {RW{1'b1}};
    localparam logic [CW-1:0] CTR_TOP  = {CW{1'b1}};
    localparam logic [CW-1:0] CTR_START = CW'(1);

    // input capture
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic             way_ok_reg, upd_reg, hit_reg;
    logic [SIG_W-1:0] sig_new_reg;
    logic [CW-1:0]    trained_reg;
    logic [CLR_W:0]   clr_reg;
    logic [CW-1:0]    ctr_trained;

    logic [PC_W-1:0]     pc_sh;
    logic [WAY_IN_W-1:0] way_in;

    assign way_in = s_tdata[SET_IN_W +: WAY_IN_W];
    assign pc_sh  = s_tdata[SET_IN_W+WAY_IN_W +: PC_W] >> shift;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            set_reg     <= SET_W'(s_tdata[SET_IN_W-1:0]);
            way_reg     <= WAY_W'(way_in);
            way_ok_reg  <= ({1'b0, way_in} < (WAY_IN_W+1)'(NUM_WAYS)) ||
                           (NUM_WAYS > 16);
            upd_reg     <= s_tuser[0];
            hit_reg     <= s_tuser[1];
            sig_new_reg <= pc_sh[SIG_W-1:0];
        end
        if (cmd.train) begin
            trained_reg <= ctr_trained;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // RAMs
    logic             row_we;
    logic [SET_W-1:0] row_waddr;
    logic [ROW_W-1:0] row_wdata, row_rdata;
    logic             ctr_we, ctr_re;
    logic [SIG_W-1:0] ctr_waddr, ctr_raddr;
    logic [CW-1:0]    ctr_wdata, ctr_rdata;

    srrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .re(cmd.accept), .raddr(SET_W'(s_tdata[SET_IN_W-1:0])), .rdata(row_rdata)
    );

    srrip_ram #(.WIDTH(CW), .DEPTH(SIGNATURE_ENTRIES)) u_ctr_ram (
        .aclk(aclk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
        .re(ctr_re), .raddr(ctr_raddr), .rdata(ctr_rdata)
    );

    // row fields
    logic [RW-1:0]    rrpv    [NUM_WAYS];
    logic [RW-1:0]    aged    [NUM_WAYS];
    logic [SIG_W-1:0] sig_old;
    logic             reused_old;
    logic [RW-1:0]    rmax, gap;
    logic [WAY_W-1:0] victim;
    logic [CW-1:0]    ctr_up, ctr_new;
    logic [RW-1:0]    ins_val;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv[w] = row_rdata[w*RW +: RW];
        end
        sig_old    = row_rdata[SIG_LO + int'(way_reg)*SIG_W +: SIG_W];
        reused_old = row_rdata[RU_LO + int'(way_reg)];
        rmax = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            rmax = (rrpv[w] > rmax) ? rrpv[w] : rmax;
        end
        gap = RRPV_TOP - rmax;
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            aged[w] = rrpv[w] + gap;
            if (rrpv[w] == rmax) victim = WAY_W'(w);
        end
    end

    always_comb begin
        ctr_up      = (ctr_rdata == CTR_TOP) ? ctr_rdata : ctr_rdata + 1'b1;
        ctr_trained = reused_old ? ctr_up :
                      (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - 1'b1;
        // new signature may alias the one just trained
        ctr_new = (sig_new_reg == sig_old) ? trained_reg : ctr_rdata;
        priority if (CMP_W'(ctr_new) >= CMP_W'(thr)) begin
            ins_val = '0;
        end else if (ctr_new == '0) begin
            ins_val = RRPV_TOP;
        end else begin
            ins_val = RRPV_TOP - 1'b1;
        end
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = row_rdata;
        ctr_we    = 1'b0;
        ctr_waddr = sig_old;
        ctr_wdata = ctr_up;
        ctr_re    = 1'b0;
        ctr_raddr = sig_old;
        if (cmd.clr_wr) begin
            row_we    = ({1'b0, clr_reg} < (CLR_W+2)'(NUM_SETS));
            row_waddr = clr_reg[SET_W-1:0];
            row_wdata = '0;
            for (int w = 0; w < NUM_WAYS; w++) row_wdata[w*RW +: RW] = RRPV_TOP;
            ctr_we    = ({1'b0, clr_reg} < (CLR_W+2)'(SIGNATURE_ENTRIES));
            ctr_waddr = clr_reg[SIG_W-1:0];
            ctr_wdata = CTR_START;
        end
        if (cmd.rd_ctr_old) ctr_re = 1'b1;
        if (cmd.fin_victim) begin
            row_we = 1'b1;
            for (int w = 0; w < NUM_WAYS; w++) row_wdata[w*RW +: RW] = aged[w];
        end
        if (cmd.fin_hit) begin
            row_we = 1'b1;
            row_wdata[int'(way_reg)*RW +: RW] = '0;
            row_wdata[RU_LO + int'(way_reg)]  = 1'b1;
            ctr_we = 1'b1;
        end
        if (cmd.train) begin
            ctr_we    = 1'b1;
            ctr_wdata = ctr_trained;
            ctr_re    = 1'b1;
            ctr_raddr = sig_new_reg;
        end
        if (cmd.fin_ins) begin
            row_we = 1'b1;
            row_wdata[int'(way_reg)*RW +: RW]             = ins_val;
            row_wdata[SIG_LO + int'(way_reg)*SIG_W +: SIG_W] = sig_new_reg;
            row_wdata[RU_LO + int'(way_reg)]              = 1'b0;
        end
    end

    // output register
    logic                m_valid_reg, m_answer_reg;
    logic [VICTIM_W-1:0] m_way_reg;
    logic                fin_any;

    assign fin_any = cmd.fin_victim | cmd.fin_hit | cmd.fin_ins | cmd.fin_nop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_any) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_any) begin
            m_answer_reg <= cmd.fin_victim;
            m_way_reg    <= cmd.fin_victim ? VICTIM_W'(victim) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_way_reg);
    assign m_tuser  = m_answer_reg;

    assign sts.clr_last  = ({1'b0, clr_reg} == (CLR_W+1)'(CLR_N - 1));
    assign sts.is_update = upd_reg;
    assign sts.is_hit    = hit_reg;
    assign sts.way_ok    = way_ok_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

endmodule
`default_nettype wire

// ===== hw/rtl/ship_rrip_replacement_top.sv =====
// SHiP-style RRIP cache replacement engine.
// Channels: s_* carries requests (tuser[0] command: 0 victim, 1 update;
// tuser[1] hit), m_* carries one result per request (tdata[3:0] victim
// way, tuser victim-answer flag). APB port sets reuse threshold (0x0)
// and signature shift (0x4).
// Steps: a victim request or an out-of-range way update reads its row and
// then finishes, a hit update also reads the counter, a miss fill also
// trains it; one request is in flight at a time, set by the simple dual-port
// line and counter RAMs (row read, counter read, counter write plus read, row write).
// Reset: a clearing pass writes every line row and every signature
// counter with s_tready low; APB writes are taken throughout.
// Stall: a result waits in the output register; a following request is
// accepted and processed but holds its final write-back until the
// output register is free.
// Depends on srrip_pkg, srrip_ctrl, srrip_dp, srrip_ram.
`default_nettype none
module ship_rrip_replacement_top
    import srrip_pkg::*;
#(
    parameter int NUM_SETS          = DEF_NUM_SETS,
    parameter int NUM_WAYS          = DEF_NUM_WAYS,
    parameter int SIGNATURE_ENTRIES = DEF_SIGNATURE_ENTRIES,
    parameter int RRPV_WIDTH        = DEF_RRPV_WIDTH,
    parameter int COUNTER_WIDTH     = DEF_COUNTER_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // set_index, way, pc, zero pad
    input  wire logic [S_TUSER_W-1:0]  s_tuser,  // command, hit
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // victim_way, zero pad
    output logic                       m_tuser,  // victim_answer
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [THR_W-1:0]   thr_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THR_RESET;
            shift_reg <= SHIFT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_THRESHOLD: thr_reg   <= pwdata[THR_W-1:0];
                REG_SHIFT:     shift_reg <= pwdata[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_SHIFT) ? APB_DATA_W'(shift_reg)
                                            : APB_DATA_W'(thr_reg);

    srrip_cmd_t cmd;
    srrip_sts_t sts;

    srrip_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid),
        .s_tready(s_tready), .sts(sts), .cmd(cmd)
    );

    srrip_dp #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
        .SIGNATURE_ENTRIES(SIGNATURE_ENTRIES),
        .RRPV_WIDTH(RRPV_WIDTH), .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .thr(thr_reg), .shift(shift_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule
`default_nettype wire

// ===== verif/ship_rrip_replacement_top_tb.sv =====
// Self-checking testbench for ship_rrip_replacement_top: drives victim and update
// transactions, predicts every result with a behavioural copy of the replacement state.
// Depends on srrip_pkg and the RTL of the block.
`default_nettype none
module ship_rrip_replacement_top_tb;
    import srrip_pkg::*;

    localparam int SETS = DEF_NUM_SETS;
    localparam int WAYS = DEF_NUM_WAYS;
    localparam int SIGS = DEF_SIGNATURE_ENTRIES;
    localparam logic [1:0] LINE_TOP = 2'd3;
    localparam logic [1:0] CTR_MAX  = 2'd3;
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;
    localparam longint LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       victim_answer;
    } repl_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // set_index, way, pc, zero pad
    logic [S_TUSER_W-1:0] s_tuser = '0;  // command, hit
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // victim_way, zero pad
    logic m_tuser;                       // victim_answer
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ship_rrip_replacement_top dut (.*);

    always #6 aclk = ~aclk;

    // shadow replacement state
    logic [1:0]  line_rrpv [SETS*WAYS];
    logic [13:0] line_sig  [SETS*WAYS];
    logic        line_reused [SETS*WAYS];
    logic [1:0]  sig_ctr [SIGS];
    logic [1:0]  thr_shadow = THR_RESET;
    logic [5:0]  shift_shadow = SHIFT_RESET;

    repl_result_t expected_results[$];
    int errors = 0, n_victim = 0, n_hit = 0, n_fill = 0, n_results = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    longint cycles = 0;

    initial begin
        for (int i = 0; i < SETS*WAYS; i++) begin
            line_rrpv[i] = LINE_TOP; line_sig[i] = '0; line_reused[i] = 1'b0;
        end
        for (int i = 0; i < SIGS; i++) sig_ctr[i] = 2'd1;
    end

    function automatic repl_result_t predict_replacement(logic cmd, logic [10:0] set_i,
            logic [3:0] way, logic hit, logic [63:0] pc);
        repl_result_t r;
        int base, ln;
        logic [1:0] best, gap, c;
        logic [13:0] old_sig, new_sig;
        base = int'(set_i) * WAYS;
        r = '0;
        if (cmd == CMD_VICTIM) begin
            best = 2'd0;
            for (int w = 0; w < WAYS; w++)
                if (line_rrpv[base+w] > best) best = line_rrpv[base+w];
            gap = LINE_TOP - best;
            for (int w = 0; w < WAYS; w++) line_rrpv[base+w] += gap;
            for (int w = WAYS-1; w >= 0; w--)
                if (line_rrpv[base+w] == LINE_TOP) r.victim_way = 4'(w);
            r.victim_answer = 1'b1;
            return r;
        end
        ln = base + int'(way);
        old_sig = line_sig[ln];
        if (hit) begin
            line_rrpv[ln] = 2'd0;
            line_reused[ln] = 1'b1;
            if (sig_ctr[old_sig] < CTR_MAX) sig_ctr[old_sig]++;
        end else begin
            if (line_reused[ln]) begin
                if (sig_ctr[old_sig] < CTR_MAX) sig_ctr[old_sig]++;
            end else if (sig_ctr[old_sig] > 0) begin
                sig_ctr[old_sig]--;
            end
            new_sig = 14'(pc >> shift_shadow);
            line_sig[ln] = new_sig;
            line_reused[ln] = 1'b0;
            c = sig_ctr[new_sig];
            if (c >= thr_shadow) line_rrpv[ln] = 2'd0;
            else if (c == 0) line_rrpv[ln] = LINE_TOP;
            else line_rrpv[ln] = LINE_TOP - 2'd1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall and result checking
    always @(posedge aclk) begin
        repl_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: victim_way %0d victim_answer %0d",
                       m_tdata[3:0], m_tuser);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[3:0] !== exp_r.victim_way) begin
                    $error("victim_way expected %0d actual %0d", exp_r.victim_way, m_tdata[3:0]);
                    errors++;
                end
                if (m_tuser !== exp_r.victim_answer) begin
                    $error("victim_answer expected %0d actual %0d", exp_r.victim_answer, m_tuser);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // tvalid stays up after acceptance; the next call drops it only while it idles, the drain always
    task automatic send_request(logic cmd, logic [10:0] set_i, logic [3:0] way, logic hit,
            logic [63:0] pc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pc, way, set_i};
        s_tuser  <= {hit, cmd};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_replacement(cmd, set_i, way, hit, pc));
        if (cmd == CMD_VICTIM) n_victim++;
        else if (hit) n_hit++;
        else n_fill++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr[2] == REG_THRESHOLD) thr_shadow = val[1:0];
        else shift_shadow = val[5:0];
        @(posedge aclk);
    endtask

    task automatic test_directed();
        // victim on a fresh set, fills at each extreme, hit then evict with reuse
        send_request(CMD_VICTIM, 11'd0, 4'd0, 1'b0, 64'd0);
        send_request(CMD_UPDATE, 11'd2047, 4'd15, 1'b0, '1);
        send_request(CMD_UPDATE, 11'd2047, 4'd15, 1'b1, '1);
        send_request(CMD_VICTIM, 11'd2047, 4'd0, 1'b1, '1);
        send_request(CMD_UPDATE, 11'd2047, 4'd15, 1'b0, 64'h10);
        send_request(CMD_UPDATE, 11'd5, 4'd0, 1'b0, 64'h1230);
        send_request(CMD_UPDATE, 11'd5, 4'd0, 1'b0, 64'h1230);  // no reuse trains down
        send_request(CMD_UPDATE, 11'd5, 4'd1, 1'b0, 64'h1230);  // counter zero: distant
        send_request(CMD_VICTIM, 11'd5, 4'd0, 1'b0, 64'h0);
        for (int w = 0; w < WAYS; w++) send_request(CMD_UPDATE, 11'd9, 4'(w), 1'b1, 64'd0);
        send_request(CMD_VICTIM, 11'd9, 4'd3, 1'b0, 64'hAAAA_5555_AAAA_5555); // full aging
        drain_results();
    endtask

    task automatic test_random(int count, int hot_sets);
        logic [10:0] s;
        logic [63:0] pc;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            s = (k < 85) ? 11'($urandom_range(hot_sets-1)) : 11'($urandom);
            pc = {$urandom, $urandom};
            if (k < 60) pc = {52'h0, 4'($urandom_range(3)), 8'($urandom_range(15)) << 4};
            k = $urandom_range(99);
            if (k < 35) send_request(CMD_VICTIM, s, 4'($urandom), 1'($urandom), pc);
            else if (k < 65) send_request(CMD_UPDATE, s, 4'($urandom), 1'b1, pc);
            else send_request(CMD_UPDATE, s, 4'($urandom), 1'b0, pc);
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150, 4);
        write_register(3'd0, 32'd1); write_register(3'd4, 32'd0);
        send_idle_pct = 45;
        test_random(150, 4);
        write_register(3'd0, 32'd3); write_register(3'd4, 32'd50);
        send_idle_pct = 0; recv_stall_pct = 45;
        test_random(150, 8);
        write_register(3'd0, 32'd2); write_register(3'd4, 32'd4);
        send_idle_pct = 25; recv_stall_pct = 25;
        test_random(150, 4);
        write_register(3'd0, 32'd1); write_register(3'd4, 32'd13);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(150, 16);
        $display("Covered %0d victim, %0d hit, %0d fill transactions; %0d results checked",
                 n_victim, n_hit, n_fill, n_results);
        $display("across thresholds 1..3, signature shifts 0..50 and four idling profiles");
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_ram.sv
hw/rtl/srrip_ctrl.sv
hw/rtl/srrip_dp.sv
hw/rtl/ship_rrip_replacement_top.sv
verif/ship_rrip_replacement_top_tb.sv
